// ===== src/pstd_pkg.sv =====
// Shared types, codes and constants for the process state table with dispatch.
package pstd_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int PID_W = 16;
  localparam int WAIT_W = 16;

  localparam logic [WAIT_W-1:0] WAIT_INIT = WAIT_W'(2);
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_BLOCK,
    OP_WAKE,
    OP_KILL
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_DUPLICATE,
    ST_NOT_FOUND,
    ST_NOT_RUNNING,
    ST_NOT_BLOCKED,
    ST_FULL
  } status_t;

  typedef enum logic [1:0] {
    MODE_BLOCKED,
    MODE_RUNNING,
    MODE_READY,
    MODE_ABSENT
  } mode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [PID_W-1:0]  process_id;
  } pstd_req_t;

  typedef struct packed {
    status_t           status;
    mode_t             target_state;
    logic [WAIT_W-1:0] target_wait;
    logic              running_valid;
    logic [PID_W-1:0]  running_id;
  } pstd_rsp_t;

  typedef enum logic [1:0] {
    SCAN_FIND,
    SCAN_SHIFT,
    SCAN_DISP,
    SCAN_REPORT
  } scan_kind_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_BLOCK,
    WR_WAKE,
    WR_PROMOTE
  } wr_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_start;
    scan_kind_t scan_kind;
    wr_kind_t   wr_kind;
    logic       dec_count;
    logic       emit;
    status_t    status;
  } pstd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    scan_done;
    opcode_t opcode;
    logic    found;
    mode_t   found_mode;
    logic    full;
    logic    promote_ok;
  } pstd_stat_t;

endpackage

// ===== src/process_state_table_dispatch.sv =====
// Top level of the process state table with dispatch.
//
//   Channel   Ports                              Moves
//   input     in_valid, in_stall, in_data        one command request (opcode, process_id)
//   output    out_valid, out_stall, out_data     one result per request
//
// A request takes one find scan over the table, an optional shift scan for a
// kill, a dispatch scan for create, block and kill, and a report scan. Each
// scan reads the table one entry per cycle over the current entries, and
// control steps lie between the scans.
// Reset is synchronous and active low; it empties the table, clears control and
// holds in_stall high.
// The block takes a new request while the previous result waits under out_stall;
// it holds the new result back only until the output register is free.
module process_state_table_dispatch #(
  parameter int MAX_PROCS = pstd_pkg::MAX_PROCS_DEF,
  parameter int ID_BITS   = pstd_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pstd_pkg::pstd_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pstd_pkg::pstd_rsp_t out_data
);
  import pstd_pkg::*;

  // Command and status buses between the sequencer and the table datapath.
  pstd_cmd_t  cmd;
  pstd_stat_t st;

  // The controller walks each request through its scans and decides the
  // status code from what the find scan reports.
  pstd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the ordered table in memory, runs the scans and
  // builds the result from the last report scan.
  pstd_dp #(
    .MAX_PROCS (MAX_PROCS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

// ===== src/pstd_dp.sv =====
// Datapath: process table memory, scan engine, request and result registers.
module pstd_dp #(
  parameter int MAX_PROCS = pstd_pkg::MAX_PROCS_DEF,
  parameter int ID_BITS   = pstd_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pstd_pkg::pstd_req_t   in_data,
  input  pstd_pkg::pstd_cmd_t   cmd,
  output pstd_pkg::pstd_stat_t  st,
  output pstd_pkg::pstd_rsp_t   out_data
);
  import pstd_pkg::*;

  localparam int AW    = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  typedef struct packed {
    logic [ID_BITS-1:0] key;
    mode_t              mode;
    logic [WAIT_W-1:0]  wcnt;
  } ent_t;

  ent_t mem [MAX_PROCS];
  ent_t rd_q;

  logic [CNT_W-1:0]   count_r;
  opcode_t            op_r;
  logic [ID_BITS-1:0] key_r;

  logic               scan_act_r;
  scan_kind_t         kind_r;
  logic [CNT_W-1:0]   idx_r;
  logic               rv_r;
  logic [AW-1:0]      ridx_r;

  logic               found_r;
  logic [AW-1:0]      slot_r;
  mode_t              fmode_r;
  logic [WAIT_W-1:0]  fwait_r;

  logic               any_run_r;
  logic               pr_found_r;
  logic [AW-1:0]      pr_slot_r;
  logic [ID_BITS-1:0] pr_key_r;

  logic               tgt_found_r;
  mode_t              tgt_mode_r;
  logic [WAIT_W-1:0]  tgt_wait_r;
  logic               run_found_r;
  logic [ID_BITS-1:0] run_id_r;

  pstd_rsp_t          out_r;

  logic               issue;
  logic               scan_done;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  ent_t               wr_data;
  logic [WAIT_W-1:0]  wait_inc;

  assign issue     = scan_act_r && (idx_r < count_r);
  assign scan_done = scan_act_r && !issue && !rv_r;
  assign wait_inc  = (rd_q.wcnt == WAIT_MAX) ? rd_q.wcnt : rd_q.wcnt + WAIT_W'(1);

  // Scan write-back takes the port while a read result is in flight; single-entry
  // updates from the controller only come between scans.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = ridx_r;
    wr_data = rd_q;
    if (rv_r && kind_r == SCAN_SHIFT) begin
      mem_we  = 1'b1;
      wr_addr = ridx_r - AW'(1);
      wr_data = rd_q;
    end else if (rv_r && kind_r == SCAN_DISP && rd_q.mode == MODE_READY) begin
      mem_we  = 1'b1;
      wr_addr = ridx_r;
      wr_data = '{key: rd_q.key, mode: MODE_READY, wcnt: wait_inc};
    end else begin
      case (cmd.wr_kind)
        WR_APPEND: begin
          mem_we  = 1'b1;
          wr_addr = count_r[AW-1:0];
          wr_data = '{key: key_r, mode: MODE_READY, wcnt: WAIT_INIT};
        end
        WR_BLOCK: begin
          mem_we  = 1'b1;
          wr_addr = slot_r;
          wr_data = '{key: key_r, mode: MODE_BLOCKED, wcnt: fwait_r};
        end
        WR_WAKE: begin
          mem_we  = 1'b1;
          wr_addr = slot_r;
          wr_data = '{key: key_r, mode: MODE_READY, wcnt: WAIT_INIT};
        end
        WR_PROMOTE: begin
          mem_we  = 1'b1;
          wr_addr = pr_slot_r;
          wr_data = '{key: pr_key_r, mode: MODE_RUNNING, wcnt: WAIT_INIT};
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[idx_r[AW-1:0]];
    end
  end

  // Scan engine and table count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_act_r <= 1'b0;
      rv_r       <= 1'b0;
    end else begin
      rv_r <= issue;
      if (issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (scan_done) begin
        scan_act_r <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        idx_r      <= (cmd.scan_kind == SCAN_SHIFT) ? CNT_W'(slot_r) + CNT_W'(1) : '0;
      end
      if (cmd.wr_kind == WR_APPEND) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Per-scan capture registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      ridx_r <= idx_r[AW-1:0];
    end
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      key_r <= ID_BITS'(in_data.process_id);
    end
    if (cmd.scan_start) begin
      kind_r <= cmd.scan_kind;
      case (cmd.scan_kind)
        SCAN_FIND: begin
          found_r <= 1'b0;
        end
        SCAN_DISP: begin
          any_run_r  <= 1'b0;
          pr_found_r <= 1'b0;
        end
        SCAN_REPORT: begin
          tgt_found_r <= 1'b0;
          run_found_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (rv_r) begin
      case (kind_r)
        SCAN_FIND: begin
          if (!found_r && rd_q.key == key_r) begin
            found_r <= 1'b1;
            slot_r  <= ridx_r;
            fmode_r <= rd_q.mode;
            fwait_r <= rd_q.wcnt;
          end
        end
        SCAN_DISP: begin
          if (rd_q.mode == MODE_RUNNING) begin
            any_run_r <= 1'b1;
          end
          if (!pr_found_r && rd_q.mode == MODE_READY) begin
            pr_found_r <= 1'b1;
            pr_slot_r  <= ridx_r;
            pr_key_r   <= rd_q.key;
          end
        end
        SCAN_REPORT: begin
          if (!tgt_found_r && rd_q.key == key_r) begin
            tgt_found_r <= 1'b1;
            tgt_mode_r  <= rd_q.mode;
            tgt_wait_r  <= rd_q.wcnt;
          end
          if (!run_found_r && rd_q.mode == MODE_RUNNING) begin
            run_found_r <= 1'b1;
            run_id_r    <= rd_q.key;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status        <= cmd.status;
      out_r.target_state  <= tgt_found_r ? tgt_mode_r : MODE_ABSENT;
      out_r.target_wait   <= tgt_found_r ? tgt_wait_r : '0;
      out_r.running_valid <= run_found_r;
      out_r.running_id    <= run_found_r ? PID_W'(run_id_r) : '0;
    end
  end

  assign out_data      = out_r;
  assign st.scan_done  = scan_done;
  assign st.opcode     = op_r;
  assign st.found      = found_r;
  assign st.found_mode = fmode_r;
  assign st.full       = (count_r == CNT_W'(MAX_PROCS));
  assign st.promote_ok = !any_run_r && pr_found_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("table count above capacity");

  a_no_cmd_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> cmd.wr_kind == WR_NONE)
    else $error("entry update collides with scan write-back");

  a_dec_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_count |-> (found_r && count_r != '0))
    else $error("removal without a found entry");
`endif

endmodule

// ===== src/pstd_ctrl.sv =====
// Controller: sequences find, shift, dispatch and report scans for each request.
module pstd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pstd_pkg::pstd_stat_t st,
  output pstd_pkg::pstd_cmd_t  cmd
);
  import pstd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_DISP,
    S_REPORT,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.status    = status_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SCAN_FIND;
          state_nxt      = S_FIND;
        end
      end
      S_FIND: begin
        if (st.scan_done) begin
          status_nxt     = ST_OK;
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SCAN_REPORT;
          state_nxt      = S_REPORT;
          case (st.opcode)
            OP_CREATE: begin
              if (st.found) begin
                status_nxt = ST_DUPLICATE;
              end else if (st.full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.wr_kind   = WR_APPEND;
                cmd.scan_kind = SCAN_DISP;
                state_nxt     = S_DISP;
              end
            end
            OP_BLOCK: begin
              if (!st.found) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                if (st.found_mode == MODE_RUNNING) begin
                  cmd.wr_kind = WR_BLOCK;
                end else begin
                  status_nxt = ST_NOT_RUNNING;
                end
                cmd.scan_kind = SCAN_DISP;
                state_nxt     = S_DISP;
              end
            end
            OP_WAKE: begin
              if (!st.found) begin
                status_nxt = ST_NOT_FOUND;
              end else if (st.found_mode == MODE_BLOCKED) begin
                cmd.wr_kind = WR_WAKE;
              end else begin
                status_nxt = ST_NOT_BLOCKED;
              end
            end
            OP_KILL: begin
              if (!st.found) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                cmd.scan_kind = SCAN_SHIFT;
                state_nxt     = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (st.scan_done) begin
          cmd.dec_count  = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SCAN_DISP;
          state_nxt      = S_DISP;
        end
      end
      S_DISP: begin
        if (st.scan_done) begin
          if (st.promote_ok) begin
            cmd.wr_kind = WR_PROMOTE;
          end
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SCAN_REPORT;
          state_nxt      = S_REPORT;
        end
      end
      S_REPORT: begin
        if (st.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No request is taken while reset is held.
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit step");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st.scan_done |-> (state_r == S_FIND || state_r == S_SHIFT ||
                      state_r == S_DISP || state_r == S_REPORT))
    else $error("scan finished while no scan was expected");
`endif

endmodule

// ===== tb/sv/process_state_table_dispatch_test.sv =====
// Self-checking testbench for the process state table with dispatch.
`timescale 1ns / 1ps

module process_state_table_dispatch_test;
  import pstd_pkg::*;

  localparam int TABLE_DEPTH = MAX_PROCS_DEF;
  localparam int RANDOM_REQUESTS = 1820;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD_CYCLES = 400;
  // Sized to outlast the slowest request, so this covers any tail.
  localparam int DRAIN_CYCLES = 100;

  // Shadow of the process table. It replays every accepted request and keeps
  // the report that the block owes for it, oldest first.
  class process_table_scoreboard;
    logic [PID_W-1:0]  slot_id[TABLE_DEPTH];
    mode_t             slot_mode[TABLE_DEPTH];
    logic [WAIT_W-1:0] slot_wait[TABLE_DEPTH];
    int                slot_count;
    pstd_rsp_t         owed_reports[$];
    int unsigned       error_count;
    int unsigned       status_tally[6];

    function new();
      slot_count = 0;
      error_count = 0;
      foreach (status_tally[k]) status_tally[k] = 0;
    endfunction

    function int locate(logic [PID_W-1:0] key);
      int i;
      int hit;
      hit = -1;
      for (i = slot_count - 1; i >= 0; i--)
        if (slot_id[i] == key) hit = i;
      return hit;
    endfunction

    // Ages every ready entry, then hands the processor to the first ready
    // entry when nothing holds it.
    function void run_dispatch();
      int i;
      bit busy;
      bit promoted;
      busy = 1'b0;
      promoted = 1'b0;
      for (i = 0; i < slot_count; i++) begin
        if (slot_mode[i] == MODE_READY && slot_wait[i] != WAIT_MAX) slot_wait[i]++;
        if (slot_mode[i] == MODE_RUNNING) busy = 1'b1;
      end
      if (!busy) begin
        for (i = 0; i < slot_count; i++) begin
          if (!promoted && slot_mode[i] == MODE_READY) begin
            slot_mode[i] = MODE_RUNNING;
            slot_wait[i] = WAIT_INIT;
            promoted = 1'b1;
          end
        end
      end
    endfunction

    function void note_command(pstd_req_t req);
      int s;
      int i;
      status_t st;
      pstd_rsp_t rep;
      s = locate(req.process_id);
      st = ST_OK;
      if (req.opcode == OP_CREATE) begin
        if (s >= 0) begin
          st = ST_DUPLICATE;
        end else if (slot_count >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          slot_id[slot_count] = req.process_id;
          slot_mode[slot_count] = MODE_READY;
          slot_wait[slot_count] = WAIT_INIT;
          slot_count++;
          run_dispatch();
        end
      end else if (s < 0) begin
        st = ST_NOT_FOUND;
      end else if (req.opcode == OP_BLOCK) begin
        if (slot_mode[s] == MODE_RUNNING) slot_mode[s] = MODE_BLOCKED;
        else st = ST_NOT_RUNNING;
        run_dispatch();
      end else if (req.opcode == OP_WAKE) begin
        if (slot_mode[s] == MODE_BLOCKED) begin
          slot_mode[s] = MODE_READY;
          slot_wait[s] = WAIT_INIT;
        end else begin
          st = ST_NOT_BLOCKED;
        end
      end else begin
        for (i = s; i + 1 < slot_count; i++) begin
          slot_id[i] = slot_id[i + 1];
          slot_mode[i] = slot_mode[i + 1];
          slot_wait[i] = slot_wait[i + 1];
        end
        slot_count--;
        run_dispatch();
      end

      s = locate(req.process_id);
      rep.status = st;
      if (s >= 0) begin
        rep.target_state = slot_mode[s];
        rep.target_wait = slot_wait[s];
      end else begin
        rep.target_state = MODE_ABSENT;
        rep.target_wait = '0;
      end
      rep.running_valid = 1'b0;
      rep.running_id = '0;
      for (i = slot_count - 1; i >= 0; i--) begin
        if (slot_mode[i] == MODE_RUNNING) begin
          rep.running_valid = 1'b1;
          rep.running_id = slot_id[i];
        end
      end
      owed_reports.push_back(rep);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(pstd_rsp_t got);
      pstd_rsp_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, got);
        error_count++;
      end else begin
        want = owed_reports.pop_front();
        status_tally[want.status]++;
        compare_field("status", want.status, got.status);
        compare_field("target_state", want.target_state, got.target_state);
        compare_field("target_wait", want.target_wait, got.target_wait);
        compare_field("running_valid", want.running_valid, got.running_valid);
        compare_field("running_id", want.running_id, got.running_id);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  pstd_req_t in_data;
  logic      out_valid;
  logic      out_stall;
  pstd_rsp_t out_data;

  process_state_table_dispatch dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  process_table_scoreboard table_sb = new();

  // When steady is set neither side pauses, so the block runs back to back.
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned long_holds = 0;
  int unsigned input_held_cycles = 0;
  int unsigned cycle_count;

  always #5 clk = ~clk;

  function automatic int draw_pause();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  // All sampling happens here at the rising edge, so a request is always noted
  // before the result it causes can be checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) table_sb.note_command(in_data);
      if (in_valid && in_stall) input_held_cycles++;
      if (out_valid && !out_stall) table_sb.check_result(out_data);
    end
  end

  // Result side. Before each result it stalls for a random number of cycles;
  // on request it first holds off for a long stretch so that the block backs
  // up and stalls its input.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        long_holds++;
      end
      n = draw_pause();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one request after a random gap and returns at the rising edge that
  // accepts it. Valid stays high into the next call when that one has no gap.
  task automatic send_command(input opcode_t op, input logic [PID_W-1:0] pid);
    int gap;
    gap = draw_pause();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.opcode = op;
    in_data.process_id = pid;
    do @(posedge clk); while (in_stall);
  endtask

  // Random traffic is mostly well formed: blocks aim at the running process,
  // wakes at blocked ones, kills at live entries, and creates draw from a small
  // id pool so duplicates and a full table come up often.
  task automatic send_random_command(input logic [PID_W-1:0] id_pool[20]);
    int pick;
    int i;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] sleepers[$];
    opcode_t op;
    pick = $urandom_range(0, 99);
    pid = id_pool[$urandom_range(0, 19)];
    if (pick < 5) begin
      op = opcode_t'($urandom_range(0, 3));
      pid = PID_W'($urandom_range(0, 65535));
    end else if (pick < 35) begin
      op = OP_CREATE;
    end else if (pick < 60) begin
      op = OP_BLOCK;
      if ($urandom_range(0, 3) != 0) begin
        for (i = 0; i < table_sb.slot_count; i++)
          if (table_sb.slot_mode[i] == MODE_RUNNING) pid = table_sb.slot_id[i];
      end
    end else if (pick < 80) begin
      op = OP_WAKE;
      for (i = 0; i < table_sb.slot_count; i++)
        if (table_sb.slot_mode[i] == MODE_BLOCKED) sleepers.push_back(table_sb.slot_id[i]);
      if (sleepers.size() > 0 && $urandom_range(0, 3) != 0)
        pid = sleepers[$urandom_range(0, sleepers.size() - 1)];
    end else begin
      op = OP_KILL;
      if (table_sb.slot_count > 0 && $urandom_range(0, 4) != 0)
        pid = table_sb.slot_id[$urandom_range(0, table_sb.slot_count - 1)];
    end
    send_command(op, pid);
  endtask

  // Watchdog: stops a run that hangs and reports it as errors.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("process_state_table_dispatch_test: errors");
    $finish;
  end

  initial begin
    logic [PID_W-1:0] id_pool[20];
    int i;
    int guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Commands on an empty table, then the basic life cycle of two processes
    // at the id extremes.
    send_command(OP_WAKE, 16'h0000);
    send_command(OP_KILL, 16'hFFFF);
    send_command(OP_BLOCK, 16'h0000);
    send_command(OP_CREATE, 16'h0000);
    send_command(OP_CREATE, 16'hFFFF);
    send_command(OP_CREATE, 16'h0000);
    send_command(OP_WAKE, 16'hFFFF);
    send_command(OP_BLOCK, 16'hFFFF);
    send_command(OP_BLOCK, 16'h0000);
    send_command(OP_WAKE, 16'h0000);
    send_command(OP_KILL, 16'hFFFF);
    // Fill the table, then hit it with a new id and with a duplicate.
    send_command(OP_CREATE, 16'h5555);
    send_command(OP_CREATE, 16'hAAAA);
    for (i = 0; i < TABLE_DEPTH - 3; i++) send_command(OP_CREATE, PID_W'(16'h1000 + i));
    send_command(OP_CREATE, 16'h7777);
    send_command(OP_CREATE, 16'h0000);
    // A kill from the middle has to keep the order of the rest.
    send_command(OP_KILL, 16'h5555);

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 250 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        foreach (id_pool[k]) id_pool[k] = PID_W'($urandom_range(0, 65535));
      end
      if (i == 100 || i == 1000) hold_request = 1'b1;
      send_random_command(id_pool);
    end

    @(negedge clk);
    in_valid = 1'b0;
    guard = 0;
    while (table_sb.owed_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (table_sb.owed_reports.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, table_sb.owed_reports.size());
      table_sb.error_count++;
    end
    $display("Covered results: ok %0d, duplicate %0d, not found %0d, not running %0d, %s",
             table_sb.status_tally[ST_OK], table_sb.status_tally[ST_DUPLICATE],
             table_sb.status_tally[ST_NOT_FOUND], table_sb.status_tally[ST_NOT_RUNNING],
             $sformatf("not blocked %0d, full %0d.", table_sb.status_tally[ST_NOT_BLOCKED],
                       table_sb.status_tally[ST_FULL]));
    $display("Input was held off for %0d cycles; %0d long output holds were applied.",
             input_held_cycles, long_holds);
    if (table_sb.error_count == 0) begin
      $display("process_state_table_dispatch_test: clean");
    end else begin
      $display("process_state_table_dispatch_test: errors");
    end
    $finish;
  end

endmodule
